/* src/heq_pkg.sv */
package heq_pkg;

    localparam int LEVEL_W = 8;
    localparam int LEVELS = 256;
    localparam int CNT_W = 23;
    localparam logic [CNT_W-1:0] MAX_PIXELS = 23'd4194304;
    // 255.99 kept as the exact ratio 25599/100
    localparam int NUM_FACTOR = 100 * LEVELS - 1;
    localparam int TOT_W = 31;
    localparam int NUM_W = TOT_W + 15;
    localparam int DEN_W = TOT_W + 7;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_COUNT  = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_MAP    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] red_in;
        logic [LEVEL_W-1:0] green_in;
        logic [LEVEL_W-1:0] blue_in;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_out;
        logic [LEVEL_W-1:0] green_out;
        logic [LEVEL_W-1:0] blue_out;
        logic [CNT_W-1:0]   peak_count;
    } out_word_t;

    // saturating bin increment
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v >= MAX_PIXELS) ? MAX_PIXELS : v + 1'b1;
        return r;
    endfunction

endpackage

/* src/heq_divider.sv */
// restoring divider, one quotient bit per cycle, 8-bit quotient
module heq_divider import heq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     numer,
    input  logic [DEN_W-1:0]     denom,
    output logic                 done,
    output logic [LEVEL_W-1:0]   quot
);
    logic [NUM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic [3:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [NUM_W+LEVEL_W-1:0] shifted;
    logic [NUM_W+LEVEL_W-1:0] trial;

    // quotient is below 256, so compare against denom shifted by the bit weight
    always_comb begin
        shifted = {{LEVEL_W{1'b0}}, den_reg} << (cnt_reg[2:0]);
        trial   = {{LEVEL_W{1'b0}}, rem_reg} - shifted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= numer;
                den_reg  <= denom;
                q_reg    <= '0;
                cnt_reg  <= 4'd7;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if ({{LEVEL_W{1'b0}}, rem_reg} >= shifted) begin
                    rem_reg <= trial[NUM_W-1:0];
                    q_reg[cnt_reg[2:0]] <= 1'b1;
                end
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

/* src/histogram_equalizer.sv */
// Histogram equalizer for 8-bit images. Count and map words are read-modify-writes
// of 256-entry histogram memories (registered reads). A count word reads the input
// histogram bin, then writes the updated bin and the result. A map word reads the
// red and green tables, then the blue table with the output bin, then writes the
// update and result. Clear sweeps both histograms one bin a cycle. Finish sums the
// input histogram, reading then adding each bin, then for each of the 256 bins
// reads the bin, adds it to the cumulative sum, starts the divider and waits for
// its 8 shift-subtract steps and done, or writes zero when the histogram is empty.
// After reset the histograms and table are cleared by a sweep of all 256 bins,
// during which no word is accepted. Peak count is reported in every result word.
module histogram_equalizer import heq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);
    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_RMW, ST_CLEAR, ST_SUM_RD, ST_SUM,
        ST_TAB_RD, ST_TAB_DIV, ST_TAB_START, ST_TAB_WAIT, ST_OUT
    } state_t;

    state_t             state_reg;
    in_word_t           in_reg;
    out_word_t          out_reg;
    logic               out_valid_reg;
    logic [CNT_W-1:0]   peak_reg;
    logic [LEVEL_W:0]   idx_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   cdf_reg;

    // memories
    logic [CNT_W-1:0]   ihist_mem [LEVELS];
    logic [CNT_W-1:0]   ohist_mem [LEVELS];
    logic [LEVEL_W-1:0] tab_mem   [LEVELS];
    logic [CNT_W-1:0]   ihist_rd, ohist_rd;
    logic [LEVEL_W-1:0] tab_rd_r, tab_rd_g;
    logic [LEVEL_W-1:0] ih_addr, oh_addr, tab_addr_r, tab_addr_g;
    logic               ih_we, oh_we, tab_we;
    logic [LEVEL_W-1:0] ih_waddr, oh_waddr, tab_waddr;
    logic [CNT_W-1:0]   ih_wdata, oh_wdata;
    logic [LEVEL_W-1:0] tab_wdata;

    logic               div_start, div_done;
    logic [LEVEL_W-1:0] div_q;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [CNT_W-1:0]   ohist_new;
    logic               s_fire;
    logic               slot_free;

    assign slot_free = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // read addresses: the map word's red code is only known after table read
    // second table port reads green on accept, then blue from the held word
    always_comb begin
        ih_addr    = s_fire ? s_data.level : idx_reg[LEVEL_W-1:0];
        tab_addr_r = s_data.red_in;
        tab_addr_g = (state_reg == ST_RMW) ? in_reg.blue_in : s_data.green_in;
        oh_addr    = tab_rd_r;
    end

    always_ff @(posedge aclk) begin
        ihist_rd <= ihist_mem[ih_addr];
        tab_rd_r <= tab_mem[tab_addr_r];
        tab_rd_g <= tab_mem[tab_addr_g];
        if (ih_we) ihist_mem[ih_waddr] <= ih_wdata;
        if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    end

    // output histogram read comes in the cycle after the table read for map words
    always_ff @(posedge aclk) begin
        ohist_rd <= ohist_mem[oh_addr];
        if (oh_we) ohist_mem[oh_waddr] <= oh_wdata;
    end

    assign ohist_new = bump(ohist_rd);
    assign div_num   = NUM_W'(NUM_FACTOR) * NUM_W'(cdf_reg);
    assign div_den   = DEN_W'(total_reg) * DEN_W'(100);

    heq_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    // memory write ports
    always_comb begin
        ih_we = 1'b0; ih_waddr = idx_reg[LEVEL_W-1:0]; ih_wdata = '0;
        oh_we = 1'b0; oh_waddr = idx_reg[LEVEL_W-1:0]; oh_wdata = '0;
        tab_we = 1'b0; tab_waddr = idx_reg[LEVEL_W-1:0]; tab_wdata = '0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                ih_we = 1'b1; oh_we = 1'b1; tab_we = 1'b1;
            end
            ST_CLEAR: begin
                ih_we = 1'b1; oh_we = 1'b1;
            end
            ST_RMW: begin
                if (in_reg.mode == MODE_COUNT) begin
                    ih_we    = 1'b1;
                    ih_waddr = in_reg.level;
                    ih_wdata = bump(ihist_rd);
                end
            end
            ST_OUT: begin
                oh_we    = 1'b1;
                oh_waddr = out_reg.red_out;
                oh_wdata = ohist_new;
            end
            ST_TAB_START: div_start = (total_reg != '0);
            ST_TAB_WAIT: begin
                tab_we    = div_done || (total_reg == '0);
                tab_wdata = (total_reg == '0) ? '0 : div_q;
            end
            default: ;
        endcase
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_INIT: begin
                    if (idx_reg[LEVEL_W-1:0] == LEVEL_W'(LEVELS - 1)) begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        in_reg  <= s_data;
                        idx_reg <= '0;
                        unique case (mode_t'(s_data.mode))
                            MODE_CLEAR:  state_reg <= ST_CLEAR;
                            MODE_COUNT:  state_reg <= ST_RMW;
                            MODE_FINISH: begin
                                total_reg <= '0;
                                state_reg <= ST_SUM_RD;
                            end
                            MODE_MAP:    state_reg <= ST_RMW;
                        endcase
                    end
                end
                ST_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg[LEVEL_W-1:0] == LEVEL_W'(LEVELS - 1)) begin
                        peak_reg      <= '0;
                        out_reg       <= '{'0, '0, '0, '0};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_RMW: begin
                    if (in_reg.mode == MODE_MAP) begin
                        // red and green read done, blue and output bin reads in flight
                        out_reg.red_out   <= tab_rd_r;
                        out_reg.green_out <= tab_rd_g;
                        state_reg         <= ST_OUT;
                    end else begin
                        out_reg       <= '{'0, '0, '0, peak_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    out_reg.blue_out <= tab_rd_g;
                    if (ohist_new > peak_reg) begin
                        peak_reg           <= ohist_new;
                        out_reg.peak_count <= ohist_new;
                    end else begin
                        out_reg.peak_count <= peak_reg;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                ST_SUM_RD: state_reg <= ST_SUM;
                ST_SUM: begin
                    total_reg <= total_reg + TOT_W'(ihist_rd);
                    if (idx_reg[LEVEL_W-1:0] == LEVEL_W'(LEVELS - 1)) begin
                        idx_reg   <= '0;
                        cdf_reg   <= '0;
                        state_reg <= ST_TAB_RD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_TAB_RD: state_reg <= ST_TAB_DIV;
                ST_TAB_DIV: begin
                    cdf_reg   <= cdf_reg + TOT_W'(ihist_rd);
                    state_reg <= ST_TAB_START;
                end
                // divider starts once the cumulative sum holds the current bin
                ST_TAB_START: state_reg <= ST_TAB_WAIT;
                ST_TAB_WAIT: begin
                    if (div_done || (total_reg == '0)) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg[LEVEL_W-1:0] == LEVEL_W'(LEVELS - 1)) begin
                            out_reg       <= '{'0, '0, '0, peak_reg};
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end else begin
                            state_reg <= ST_TAB_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // no word is taken while a result is still being built
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE)) else $error("ready outside idle");
    // peak never falls on a map update
    a_peak_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> (peak_reg >= $past(peak_reg)))
        else $error("peak decreased on map");
    // result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");
endmodule
